FILE: hdl/lmc_pkg.sv
// Shared types and constants of the least-recently-used memo cache.
package lmc_pkg;

  // Field widths of one request and one result.
  localparam int TAG_W    = 32;
  localparam int HANDLE_W = 64;
  localparam int WORD_W   = 32;
  localparam int VALUE_W  = 64;
  localparam int STAMP_W  = 64;
  localparam int KW_W     = 2;

  // Register map: register index taken from the word address.
  localparam logic REG_KEY_WORDS = 1'b0;

  // Match selector values.
  localparam logic [KW_W-1:0] KW_NONE  = 2'd0;
  localparam logic [KW_W-1:0] KW_ONE   = 2'd1;
  localparam logic [KW_W-1:0] KW_TWO   = 2'd2;
  localparam logic [KW_W-1:0] KW_THREE = 2'd3;

  // Key and value part of one stored entry.
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [WORD_W-1:0]   second;
    logic [WORD_W-1:0]   first;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  // Request sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

FILE: hdl/lmc_ram.sv
// Entry storage: key/value memory and stamp memory with registered reads.
module lmc_ram #(
  parameter int ENTRIES = 256,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output lmc_pkg::entry_t                 rd_entry,
  output logic [lmc_pkg::STAMP_W-1:0]     rd_stamp,
  input  logic [AW-1:0]                   wr_addr,
  input  logic                            wr_entry_en,
  input  lmc_pkg::entry_t                 wr_entry,
  input  logic                            wr_stamp_en,
  input  logic [lmc_pkg::STAMP_W-1:0]     wr_stamp
);
  import lmc_pkg::*;

  entry_t             entry_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  // Key and value memory: one write and one read port.
  always_ff @(posedge clk) begin
    if (wr_entry_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= entry_mem[rd_addr];
    end
  end

  // Stamp memory: written on every hit and every fill.
  always_ff @(posedge clk) begin
    if (wr_stamp_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (rd_en) begin
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

FILE: hdl/lru_memo_cache.sv
// Top level of the fully associative memo cache with timestamp LRU replacement.
// A request scans the occupied slots (none when empty) and on a miss writes an entry;
// a hit ends the scan early, at the matching slot.
// One request at a time, set by the scan of the entry memory through its single read
// port, one slot a cycle through one shared compare unit.
// Reset clears occupancy, the access clock and the key word selector (to 3);
// entry memories are not cleared, as only occupied slots are ever read.
module lru_memo_cache #(
  parameter int ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst,
  // Request: tag[31:0], key_handle[95:32], key_first[127:96],
  // key_second[159:128], fill_value[223:160]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,
  // Result: result_value[63:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,
  // Result flags: hit[0], evicted[1]
  output logic [1:0]   m_tuser,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lmc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  state_t             state;
  logic [KW_W-1:0]    key_words;
  logic [CW-1:0]      occupancy;
  logic [STAMP_W-1:0] access_clock;

  entry_t             req;
  logic [CW-1:0]      scan_addr;
  logic [AW-1:0]      chk_addr;
  logic               rd_pend;
  logic [STAMP_W-1:0] oldest_stamp;
  logic [AW-1:0]      oldest_slot;

  logic               res_hit;
  logic               res_evicted;
  logic [VALUE_W-1:0] res_value;
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [1:0]         out_flags;

  logic               rd_en;
  entry_t             rd_entry;
  logic [STAMP_W-1:0] rd_stamp;
  logic [AW-1:0]      wr_addr;
  logic               wr_entry_en;
  logic               wr_stamp_en;
  logic               cfg_write;
  logic [KW_W-1:0]    kw_eff;
  logic               match;
  logic               older;
  logic               last_slot;
  logic               full;

  // Configuration access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_KEY_WORDS) ? {{(32-KW_W){1'b0}}, key_words} : 32'd0;

  // Shared compare unit: key match and stamp age of the slot just read.
  assign kw_eff    = (key_words == KW_NONE) ? KW_ONE : key_words;
  assign match     = (rd_entry.tag == req.tag) && (rd_entry.handle == req.handle)
                     && ((kw_eff < KW_TWO) || (rd_entry.first == req.first))
                     && ((kw_eff < KW_THREE) || (rd_entry.second == req.second));
  assign older     = rd_stamp < oldest_stamp;
  assign last_slot = (CW'(chk_addr) + CW'(1)) == occupancy;
  assign full      = occupancy == FULL;

  // Memory access control.
  assign rd_en       = (state == ST_SCAN) && (scan_addr < occupancy);
  assign wr_entry_en = state == ST_WRITE;
  assign wr_stamp_en = wr_entry_en || ((state == ST_SCAN) && rd_pend && match);

  always_comb begin
    if (state == ST_WRITE) begin
      wr_addr = full ? oldest_slot : occupancy[AW-1:0];
    end else begin
      wr_addr = chk_addr;
    end
  end

  lmc_ram #(.ENTRIES(ENTRIES)) u_ram (
    .clk         (clk),
    .rd_en       (rd_en),
    .rd_addr     (scan_addr[AW-1:0]),
    .rd_entry    (rd_entry),
    .rd_stamp    (rd_stamp),
    .wr_addr     (wr_addr),
    .wr_entry_en (wr_entry_en),
    .wr_entry    (req),
    .wr_stamp_en (wr_stamp_en),
    .wr_stamp    (access_clock)
  );

  // Request sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      key_words    <= KW_THREE;
      occupancy    <= '0;
      access_clock <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == REG_KEY_WORDS)) begin
        key_words <= pwdata[KW_W-1:0];
      end
      // The result register loads when the sequencer is done and the slot is free.
      if ((state == ST_DONE) && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      // A read is pending when one was issued, unless the slot just checked was the hit.
      rd_pend <= rd_en && !(rd_pend && match);
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req.tag      <= s_tdata[31:0];
            req.handle   <= s_tdata[95:32];
            req.first    <= s_tdata[127:96];
            req.second   <= s_tdata[159:128];
            req.value    <= s_tdata[223:160];
            access_clock <= access_clock + STAMP_W'(1);
            scan_addr    <= '0;
            oldest_stamp <= '1;
            oldest_slot  <= '0;
            state        <= (occupancy == '0) ? ST_WRITE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            chk_addr  <= scan_addr[AW-1:0];
            scan_addr <= scan_addr + CW'(1);
          end
          if (rd_pend) begin
            if (match) begin
              res_hit     <= 1'b1;
              res_evicted <= 1'b0;
              res_value   <= rd_entry.value;
              state       <= ST_DONE;
            end else begin
              if (older) begin
                oldest_stamp <= rd_stamp;
                oldest_slot  <= chk_addr;
              end
              if (last_slot) begin
                state <= ST_WRITE;
              end
            end
          end
        end
        ST_WRITE: begin
          res_hit     <= 1'b0;
          res_evicted <= full;
          res_value   <= req.value;
          if (!full) begin
            occupancy <= occupancy + CW'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || m_tready) begin
            out_value <= res_value;
            out_flags <= {res_evicted, res_hit};
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_flags;

endmodule

FILE: hdl/lmc_checker.sv
// Port-level checks of the memo cache, bound to the top level.
module lmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // Reset leaves the block ready and with no result pending.
  a_reset_state: assert property (@(posedge clk) rst |=> (s_tready && !m_tvalid))
    else $error("block not idle after reset");

  // One request at a time: the block is busy in the cycle after acceptance.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while a previous one is in progress");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result flags both hit and eviction");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind lru_memo_cache lmc_checker u_lmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
